/* design/octenc_pkg.sv */
// Shared types and constants of the octahedral normal encoder.
package octenc_pkg;

   localparam int OCT_COMPONENT_BITS = 16;
   localparam int OCT_QUOT_BITS      = 15;
   localparam int OCT_HALF_BITS      = 16;
   localparam int OCT_WORD_BITS      = 2 * OCT_HALF_BITS;
   localparam int OCT_SNORM_MAX      = 32767;
   localparam int OCT_TWICE_MAX      = 2 * OCT_SNORM_MAX;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero;
   } side_type;

endpackage

/* design/octahedral_normal_encoder.sv */
// Top level of the octahedral normal encoder: fold, scale, divide and pack.
//
//   Channel   Direction   Word contents
//   req_      in          dir_x, dir_y, dir_z
//   rsp_      out         oct_word
//
// One word is accepted per cycle unless rsp_ stalls; each word passes stages A, B and C,
// then the divider, with one quotient bit per stage over 15 stages, and the output register.
// Reset clears every stage valid bit synchronously; payload registers are not reset.
// Each stage holds its word while the next is full and stalled, so bubbles are squeezed out.
module octahedral_normal_encoder
   import octenc_pkg::*;
#(
   parameter int COMPONENT_BITS = OCT_COMPONENT_BITS,
   parameter int REQ_DATA_BITS  = ((3 * COMPONENT_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // dir_x, dir_y, dir_z, then zero padding.
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // oct_word.
   output logic [OCT_WORD_BITS-1:0] rsp_tdata
);

   localparam int CB       = COMPONENT_BITS;
   localparam int LEN_BITS = CB + 1;
   localparam int NUM_BITS = CB + 17;
   localparam int DEN_BITS = CB + 2;
   localparam int QB       = OCT_QUOT_BITS;
   localparam int HB       = OCT_HALF_BITS;

   logic [CB-1:0] raw_x;
   logic [CB-1:0] raw_y;
   logic [CB-1:0] raw_z;

   logic          a_valid_ff;
   logic [CB-1:0] a_mag_x_ff;
   logic [CB-1:0] a_mag_y_ff;
   logic [CB-1:0] a_mag_z_ff;
   logic          a_neg_z_ff;
   side_type      a_side_ff;
   logic          a_ready;

   logic                b_valid_ff;
   logic [LEN_BITS-1:0] b_len_ff;
   logic [LEN_BITS-1:0] b_len_in;
   logic [LEN_BITS-1:0] b_num_x_ff;
   logic [LEN_BITS-1:0] b_num_x_in;
   logic [LEN_BITS-1:0] b_num_y_ff;
   logic [LEN_BITS-1:0] b_num_y_in;
   side_type            b_side_ff;
   logic                b_ready;

   logic                c_valid_ff;
   logic [NUM_BITS-1:0] c_num_x_ff;
   logic [NUM_BITS-1:0] c_num_x_in;
   logic [NUM_BITS-1:0] c_num_y_ff;
   logic [NUM_BITS-1:0] c_num_y_in;
   logic [DEN_BITS-1:0] c_den_ff;
   side_type            c_side_ff;
   logic                c_ready;

   logic          div_ready;
   logic          div_valid;
   logic [QB-1:0] div_quot_x;
   logic [QB-1:0] div_quot_y;
   side_type      div_side;

   logic                     out_valid_ff;
   logic [OCT_WORD_BITS-1:0] out_word_ff;
   logic [OCT_WORD_BITS-1:0] out_word_in;
   logic                     out_ready;
   logic [HB-1:0]            mag_x;
   logic [HB-1:0]            mag_y;
   logic [HB-1:0]            snorm_x;
   logic [HB-1:0]            snorm_y;

   assign raw_x = req_tdata[CB-1:0];
   assign raw_y = req_tdata[2*CB-1:CB];
   assign raw_z = req_tdata[3*CB-1:2*CB];

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign c_ready    = !c_valid_ff || div_ready;
   assign b_ready    = !b_valid_ff || c_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;

   // Stage A: magnitudes and signs.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_mag_x_ff      <= raw_x[CB-1] ? (~raw_x + CB'(1)) : raw_x;
         a_mag_y_ff      <= raw_y[CB-1] ? (~raw_y + CB'(1)) : raw_y;
         a_mag_z_ff      <= raw_z[CB-1] ? (~raw_z + CB'(1)) : raw_z;
         a_neg_z_ff      <= raw_z[CB-1];
         a_side_ff.neg_x <= raw_x[CB-1];
         a_side_ff.neg_y <= raw_y[CB-1];
         a_side_ff.zero  <= (raw_x == '0) && (raw_y == '0) && (raw_z == '0);
      end
   end

   // Stage B: length and the folded numerators; L - |y| equals |x| + |z|.
   always_comb begin
      b_len_in   = LEN_BITS'(a_mag_x_ff) + LEN_BITS'(a_mag_y_ff) + LEN_BITS'(a_mag_z_ff);
      b_num_x_in = LEN_BITS'(a_mag_x_ff) + (a_neg_z_ff ? LEN_BITS'(a_mag_z_ff) : '0);
      b_num_y_in = LEN_BITS'(a_mag_y_ff) + (a_neg_z_ff ? LEN_BITS'(a_mag_z_ff) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_len_ff   <= b_len_in;
         b_num_x_ff <= b_num_x_in;
         b_num_y_ff <= b_num_y_in;
         b_side_ff  <= a_side_ff;
      end
   end

   // Stage C: the rounding quotient is (2*max*num + L) / (2*L).
   always_comb begin
      c_num_x_in = NUM_BITS'(b_num_x_ff) * NUM_BITS'(OCT_TWICE_MAX) + NUM_BITS'(b_len_ff);
      c_num_y_in = NUM_BITS'(b_num_y_ff) * NUM_BITS'(OCT_TWICE_MAX) + NUM_BITS'(b_len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_num_x_ff <= c_num_x_in;
         c_num_y_ff <= c_num_y_in;
         c_den_ff   <= {b_len_ff, 1'b0};
         c_side_ff  <= b_side_ff;
      end
   end

   octenc_div_pipe #(
      .COMPONENT_BITS(COMPONENT_BITS),
      .NUM_BITS      (NUM_BITS),
      .DEN_BITS      (DEN_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_ready  (div_ready),
      .in_num_x  (c_num_x_ff),
      .in_num_y  (c_num_y_ff),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .out_valid (div_valid),
      .out_ready (out_ready),
      .out_quot_x(div_quot_x),
      .out_quot_y(div_quot_y),
      .out_side  (div_side)
   );

   // Output stage: apply signs, force the zero vector to zero and pack.
   always_comb begin
      mag_x       = {1'b0, div_quot_x};
      mag_y       = {1'b0, div_quot_y};
      snorm_x     = div_side.neg_x ? (~mag_x + HB'(1)) : mag_x;
      snorm_y     = div_side.neg_y ? (~mag_y + HB'(1)) : mag_y;
      out_word_in = div_side.zero ? '0 : {snorm_y, snorm_x};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;

endmodule

/* design/octenc_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module octenc_div_pipe
   import octenc_pkg::*;
#(
   parameter int COMPONENT_BITS = OCT_COMPONENT_BITS,
   parameter int NUM_BITS       = COMPONENT_BITS + 17,
   parameter int DEN_BITS       = COMPONENT_BITS + 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [NUM_BITS-1:0]      in_num_x,
   input  logic [NUM_BITS-1:0]      in_num_y,
   input  logic [DEN_BITS-1:0]      in_den,
   input  side_type                 in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [OCT_QUOT_BITS-1:0] out_quot_x,
   output logic [OCT_QUOT_BITS-1:0] out_quot_y,
   output side_type                 out_side
);

   localparam int QB = OCT_QUOT_BITS;

   logic                valid_ff [QB];
   logic [NUM_BITS-1:0] rem_x_ff [QB];
   logic [NUM_BITS-1:0] rem_y_ff [QB];
   logic [QB-1:0]       quot_x_ff [QB];
   logic [QB-1:0]       quot_y_ff [QB];
   logic [DEN_BITS-1:0] den_ff [QB];
   side_type            side_ff [QB];
   logic                stage_ready [QB+1];

   assign stage_ready[QB] = out_ready;
   assign in_ready        = stage_ready[0];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int BIT_POS = QB - 1 - s;

      logic                src_valid;
      logic [NUM_BITS-1:0] src_rem_x;
      logic [NUM_BITS-1:0] src_rem_y;
      logic [QB-1:0]       src_quot_x;
      logic [QB-1:0]       src_quot_y;
      logic [DEN_BITS-1:0] src_den;
      side_type            src_side;
      logic [NUM_BITS-1:0] den_shift;
      logic [NUM_BITS:0]   diff_x;
      logic [NUM_BITS:0]   diff_y;
      logic [NUM_BITS-1:0] rem_x_in;
      logic [NUM_BITS-1:0] rem_y_in;
      logic [QB-1:0]       quot_x_in;
      logic [QB-1:0]       quot_y_in;

      if (s == 0) begin : g_first
         assign src_valid  = in_valid;
         assign src_rem_x  = in_num_x;
         assign src_rem_y  = in_num_y;
         assign src_quot_x = '0;
         assign src_quot_y = '0;
         assign src_den    = in_den;
         assign src_side   = in_side;
      end else begin : g_next
         assign src_valid  = valid_ff[s-1];
         assign src_rem_x  = rem_x_ff[s-1];
         assign src_rem_y  = rem_y_ff[s-1];
         assign src_quot_x = quot_x_ff[s-1];
         assign src_quot_y = quot_y_ff[s-1];
         assign src_den    = den_ff[s-1];
         assign src_side   = side_ff[s-1];
      end

      assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      assign den_shift      = NUM_BITS'(src_den) << BIT_POS;

      always_comb begin
         diff_x    = {1'b0, src_rem_x} - {1'b0, den_shift};
         diff_y    = {1'b0, src_rem_y} - {1'b0, den_shift};
         rem_x_in  = diff_x[NUM_BITS] ? src_rem_x : diff_x[NUM_BITS-1:0];
         rem_y_in  = diff_y[NUM_BITS] ? src_rem_y : diff_y[NUM_BITS-1:0];
         quot_x_in = src_quot_x;
         quot_y_in = src_quot_y;
         quot_x_in[BIT_POS] = !diff_x[NUM_BITS];
         quot_y_in[BIT_POS] = !diff_y[NUM_BITS];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[s]) begin
            rem_x_ff[s]  <= rem_x_in;
            rem_y_ff[s]  <= rem_y_in;
            quot_x_ff[s] <= quot_x_in;
            quot_y_ff[s] <= quot_y_in;
            den_ff[s]    <= src_den;
            side_ff[s]   <= src_side;
         end
      end
   end

   assign out_valid  = valid_ff[QB-1];
   assign out_quot_x = quot_x_ff[QB-1];
   assign out_quot_y = quot_y_ff[QB-1];
   assign out_side   = side_ff[QB-1];

endmodule

/* design/octenc_checker.sv */
// Port-level checks of the octahedral normal encoder, bound to the top level.
module octenc_checker
   import octenc_pkg::*;
#(
   parameter int REQ_DATA_BITS = 48
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [OCT_WORD_BITS-1:0] rsp_tdata
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("Waiting input word changed or vanished.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result word changed or vanished.");

   a_no_min_snorm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] != 16'h8000) && (rsp_tdata[31:16] != 16'h8000))
      else $error("Result word carries the most negative snorm value.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("Input blocked although the output can drain.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

endmodule

bind octahedral_normal_encoder octenc_checker #(
   .REQ_DATA_BITS(REQ_DATA_BITS)
) u_octenc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
